[rtl/mtt_pkg.sv]
`default_nettype none
package mtt_pkg;

  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_FREE  = 3'd1;
  localparam logic [2:0] OP_INIT  = 3'd2;
  localparam logic [2:0] OP_ARM   = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic start;
    logic tick_inc;
    logic do_free;
    logic do_init;
    logic do_arm;
    logic alloc_step;
    logic tick_step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic alloc_done;
    logic tick_done;
    logic flush_done;
  } sts_t;

  typedef struct packed {
    logic       kind;
    logic       found;
    logic [4:0] slot;
    logic [3:0] queue;
    logic [7:0] evt;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

[rtl/mtt_ram.sv]
`default_nettype none
module mtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/mtt_ctrl.sv]
`default_nettype none
module mtt_ctrl
  import mtt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] op,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_TICK,
    S_FLUSH
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.alloc_step = (state == S_ALLOC);
    cmd.tick_step  = (state == S_TICK);
    cmd.flush      = (state == S_FLUSH);
    if (accept) begin
      case (op)
        OP_ALLOC: cmd.start = 1'b1;
        OP_FREE:  cmd.do_free = 1'b1;
        OP_INIT:  cmd.do_init = 1'b1;
        OP_ARM:   cmd.do_arm = 1'b1;
        OP_TICK: begin
          cmd.start    = 1'b1;
          cmd.tick_inc = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && op == OP_ALLOC) begin
            state <= S_ALLOC;
          end else if (accept && op == OP_TICK) begin
            state <= S_TICK;
          end
        end
        S_ALLOC: begin
          if (sts.alloc_done) begin
            state <= S_FLUSH;
          end
        end
        S_TICK: begin
          if (sts.tick_done) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (sts.flush_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/mtt_datapath.sv]
`default_nettype none
module mtt_datapath
  import mtt_pkg::*;
#(
  parameter int TIMER_SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [4:0]  slot_index,
  input  wire logic [31:0] delay_ticks,
  input  wire logic [3:0]  queue_select,
  input  wire logic [7:0]  event_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output res_t             res
);

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CW-1:0] N_C    = CW'(TIMER_SLOTS);
  localparam logic [CW-1:0] LAST_C = CW'(TIMER_SLOTS - 1);

  logic [31:0]   tick_count;
  logic [1:0]    status [TIMER_SLOTS];
  logic [CW-1:0] rd_cnt;
  logic          chk_valid;
  logic [IW-1:0] chk_idx;
  res_t          pend;
  logic          pend_valid;
  res_t          out_r;
  logic          out_valid_r;

  logic          wr_ok;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] stat_idx;
  logic [1:0]    stat_rd;
  logic          stall;
  logic          due;
  logic [IW-1:0] ram_raddr;
  logic [31:0]   dl_rdata;
  logic [11:0]   qb_rdata;

  assign wr_ok     = 32'(slot_index) < TIMER_SLOTS;
  assign wr_idx    = IW'(slot_index);
  assign rd_idx    = rd_cnt[IW-1:0];
  assign stat_idx  = cmd.tick_step ? chk_idx : rd_idx;
  assign stat_rd   = status[stat_idx];
  assign stall     = pend_valid && out_valid_r;
  assign due       = chk_valid && (stat_rd == ST_RUN) && (dl_rdata <= tick_count);
  assign ram_raddr = stall ? chk_idx : rd_idx;

  assign sts.alloc_done = (stat_rd == ST_FREE) || (rd_cnt == LAST_C);
  assign sts.tick_done  = (rd_cnt == N_C) && !chk_valid;
  assign sts.flush_done = !pend_valid || !out_valid_r;

  assign out_valid = out_valid_r;
  assign res       = out_r;

  mtt_ram #(
    .WIDTH(32),
    .DEPTH(TIMER_SLOTS)
  ) u_deadline (
    .clk  (clk),
    .we   (cmd.do_arm && wr_ok),
    .waddr(wr_idx),
    .wdata(tick_count + delay_ticks),
    .raddr(ram_raddr),
    .rdata(dl_rdata)
  );

  mtt_ram #(
    .WIDTH(12),
    .DEPTH(TIMER_SLOTS)
  ) u_event (
    .clk  (clk),
    .we   (cmd.do_init && wr_ok),
    .waddr(wr_idx),
    .wdata({queue_select, event_byte}),
    .raddr(ram_raddr),
    .rdata(qb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      rd_cnt      <= '0;
      chk_valid   <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        status[i] <= ST_FREE;
      end
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.start) begin
        rd_cnt    <= '0;
        chk_valid <= 1'b0;
      end
      if (cmd.tick_inc) begin
        tick_count <= tick_count + 32'd1;
      end
      if (cmd.do_free && wr_ok) begin
        status[wr_idx] <= ST_FREE;
      end
      if (cmd.do_arm && wr_ok) begin
        status[wr_idx] <= ST_RUN;
      end
      if (cmd.alloc_step) begin
        if (stat_rd == ST_FREE) begin
          status[stat_idx] <= ST_ALLOC;
          pend       <= '{kind: KIND_ALLOC, found: 1'b1, slot: 5'(rd_idx),
                          queue: 4'd0, evt: 8'd0, last: 1'b1};
          pend_valid <= 1'b1;
        end else if (rd_cnt == LAST_C) begin
          pend       <= '{kind: KIND_ALLOC, found: 1'b0, slot: 5'd0,
                          queue: 4'd0, evt: 8'd0, last: 1'b1};
          pend_valid <= 1'b1;
        end else begin
          rd_cnt <= rd_cnt + CW'(1);
        end
      end
      if (cmd.tick_step && !stall) begin
        if (rd_cnt != N_C) begin
          chk_valid <= 1'b1;
          chk_idx   <= rd_idx;
          rd_cnt    <= rd_cnt + CW'(1);
        end else begin
          chk_valid <= 1'b0;
        end
        if (due) begin
          status[chk_idx] <= ST_ALLOC;
          if (pend_valid) begin
            out_r       <= pend;
            out_valid_r <= 1'b1;
          end
          pend       <= '{kind: KIND_EXPIRY, found: 1'b1, slot: 5'(chk_idx),
                          queue: qb_rdata[11:8], evt: qb_rdata[7:0], last: 1'b0};
          pend_valid <= 1'b1;
        end
      end
      if (cmd.flush && pend_valid && !out_valid_r) begin
        out_r       <= '{kind: pend.kind, found: pend.found, slot: pend.slot,
                         queue: pend.queue, evt: pend.evt, last: 1'b1};
        out_valid_r <= 1'b1;
        pend_valid  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/multi_timer_table.sv]
// Timer slot table with a shared 32-bit tick counter and absolute deadlines.
// Input channel (in_valid/in_ready) takes one operation per beat: allocate,
// free, init, arm or tick. Output channel (out_valid/out_ready) returns
// result beats; last marks the final beat caused by one operation.
// Free, init and arm are done at the accept and give no result.
// Allocate walks the status flops one slot a cycle and returns one result beat.
// Tick walks the deadline and event RAMs one slot a cycle while the output
// is not stalled, through a registered read: one beat per expired slot.
// The slot walk sets the rate; in_ready is high only between operations.
// One result is held back until the next is found so that last can be set;
// a second finished beat waits in the output register, and the walk holds
// while both are full, so a stalled receiver pauses the scan and loses
// nothing. The last beat may still wait at the output while the next
// operation is taken.
// Reset frees every slot, clears the counter and empties the output; the
// deadline and event RAMs are not cleared.
`default_nettype none
module multi_timer_table
  import mtt_pkg::*;
#(
  parameter int TIMER_SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [4:0]  slot_index,
  input  wire logic [31:0] delay_ticks,
  input  wire logic [3:0]  queue_select,
  input  wire logic [7:0]  event_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic             found,
  output logic [4:0]       slot_out,
  output logic [3:0]       queue_out,
  output logic [7:0]       byte_out,
  output logic             last
);

  cmd_t cmd;
  sts_t sts;
  res_t res;

  mtt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op      (op),
    .sts     (sts),
    .cmd     (cmd)
  );

  mtt_datapath #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .slot_index  (slot_index),
    .delay_ticks (delay_ticks),
    .queue_select(queue_select),
    .event_byte  (event_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res         (res)
  );

  assign kind      = res.kind;
  assign found     = res.found;
  assign slot_out  = res.slot;
  assign queue_out = res.queue;
  assign byte_out  = res.evt;
  assign last      = res.last;

endmodule
`default_nettype wire
